>>> hdl/mali_pkg.sv
// Shared constants, types and state codes of the multi-axis linear interpolator.
package mali_pkg;

   // Axis set and angle format
   localparam int AXES_MAX        = 8;
   localparam int AXIS_COUNT      = 8;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int ANGLE_LIMIT_DEG = 270;
   localparam int ANGLE_W         = 17;
   localparam int STEP_W          = 9;
   localparam int SPEED_W         = 8;
   localparam int AXIS_IDX_W      = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int DIV_CNT_W       = $clog2(ANGLE_W + 1);

   localparam logic [31:0] ANGLE_LIMIT_Q = 32'(ANGLE_LIMIT_DEG) << ANGLE_FRAC_BITS;

   // Request codes
   localparam logic REQ_START = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STEP_DIV,
      ST_AXIS_DIV,
      ST_TICK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [ANGLE_W-1:0]   dividend;
      logic [STEP_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [ANGLE_W-1:0]   quotient;
      logic [STEP_W-1:0]    remainder;
   } div_rsp_type;

endpackage

>>> hdl/mali_ifs.sv
// Request and response channel interfaces of the multi-axis linear interpolator.
interface mali_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [mali_pkg::ANGLE_W-1:0]   target_shoulder_y;
   logic [mali_pkg::ANGLE_W-1:0]   target_shoulder_z;
   logic [mali_pkg::ANGLE_W-1:0]   target_elbow_y;
   logic [mali_pkg::ANGLE_W-1:0]   target_wrist_y;
   logic [mali_pkg::ANGLE_W-1:0]   target_grip_x;
   logic [mali_pkg::ANGLE_W-1:0]   target_grip_y;
   logic [mali_pkg::ANGLE_W-1:0]   target_grip_z;
   logic [mali_pkg::ANGLE_W-1:0]   target_grip_open;
   logic [mali_pkg::SPEED_W-1:0]   move_speed;

   modport source (
      output valid, req_type, target_shoulder_y, target_shoulder_z, target_elbow_y,
             target_wrist_y, target_grip_x, target_grip_y, target_grip_z,
             target_grip_open, move_speed,
      input  ready
   );
   modport sink (
      input  valid, req_type, target_shoulder_y, target_shoulder_z, target_elbow_y,
             target_wrist_y, target_grip_x, target_grip_y, target_grip_z,
             target_grip_open, move_speed,
      output ready
   );
endinterface

interface mali_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mali_pkg::ANGLE_W-1:0]   pos_shoulder_y;
   logic [mali_pkg::ANGLE_W-1:0]   pos_shoulder_z;
   logic [mali_pkg::ANGLE_W-1:0]   pos_elbow_y;
   logic [mali_pkg::ANGLE_W-1:0]   pos_wrist_y;
   logic [mali_pkg::ANGLE_W-1:0]   pos_grip_x;
   logic [mali_pkg::ANGLE_W-1:0]   pos_grip_y;
   logic [mali_pkg::ANGLE_W-1:0]   pos_grip_z;
   logic [mali_pkg::ANGLE_W-1:0]   pos_grip_open;
   logic                           moving;
   logic                           last_step;

   modport source (
      output valid, pos_shoulder_y, pos_shoulder_z, pos_elbow_y, pos_wrist_y,
             pos_grip_x, pos_grip_y, pos_grip_z, pos_grip_open, moving, last_step,
      input  ready
   );
   modport sink (
      input  valid, pos_shoulder_y, pos_shoulder_z, pos_elbow_y, pos_wrist_y,
             pos_grip_x, pos_grip_y, pos_grip_z, pos_grip_open, moving, last_step,
      output ready
   );
endinterface

>>> hdl/mali_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module mali_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  mali_pkg::div_req_type  div_req,
   output mali_pkg::div_rsp_type  div_rsp
);

   logic                              active_ff, active_in;
   logic                              done_ff, done_in;
   logic [mali_pkg::DIV_CNT_W-1:0]    count_ff, count_in;
   logic [mali_pkg::ANGLE_W-1:0]      quo_ff, quo_in;
   logic [mali_pkg::STEP_W-1:0]       rem_ff, rem_in;
   logic [mali_pkg::STEP_W-1:0]       sor_ff, sor_in;

   logic [mali_pkg::STEP_W:0]         trial;
   logic [mali_pkg::STEP_W:0]         diff;
   logic                              ge;

   always_comb begin
      trial     = {rem_ff, quo_ff[mali_pkg::ANGLE_W-1]};
      ge        = trial >= {1'b0, sor_ff};
      diff      = trial - {1'b0, sor_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      sor_in    = sor_ff;
      if (div_req.start) begin
         active_in = 1'b1;
         count_in  = mali_pkg::DIV_CNT_W'(mali_pkg::ANGLE_W);
         quo_in    = div_req.dividend;
         rem_in    = '0;
         sor_in    = div_req.divisor;
      end else if (active_ff) begin
         rem_in   = ge ? diff[mali_pkg::STEP_W-1:0] : trial[mali_pkg::STEP_W-1:0];
         quo_in   = {quo_ff[mali_pkg::ANGLE_W-2:0], ge};
         count_in = count_ff - 1'b1;
         if (count_ff == mali_pkg::DIV_CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      sor_ff <= sor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !active_ff)
      else $error("divider restarted while busy");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < sor_ff))
      else $error("divider remainder not below divisor");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");
`endif

endmodule

>>> hdl/multi_axis_linear_interpolator_unit.sv
// Top level of the eight-axis linear move generator.
//
// Usage: items arrive on req_ch (valid/ready). A start item (req_type 0) brings
// eight target angles (degrees, 8 fraction bits, saturated at the angle limit)
// and a speed; a tick item (req_type 1) advances a running move by one step.
// Every item gives exactly one result on rsp_ch: the pose of all axes, moving
// and last_step. A start returns the unchanged pose with moving set.
//
// Timing: one shared restoring divider (one bit a cycle) sets the cost. A
// start scans the axes, divides the step count by the speed, then divides
// each axis delta by the step count into quotient and remainder. A tick
// while moving walks the eight per-axis quotient/remainder accumulators
// through one add-and-compare unit, one axis a cycle. An idle tick goes
// straight to the result. One item at a time: req_ch.ready is high only
// while the sequencer is idle.
//
// Reset: all angles zero, no move running, no result pending.
// Stall: the result waits in an output register; the next item may be taken
// meanwhile, but its result is held back until the register is free.
module multi_axis_linear_interpolator_unit (
   input  logic         clock,
   input  logic         reset,
   mali_req_if.sink     req_ch,
   mali_rsp_if.source   rsp_ch
);

   localparam int AW = mali_pkg::ANGLE_W;
   localparam int SW = mali_pkg::STEP_W;
   localparam int IW = mali_pkg::AXIS_IDX_W;
   localparam int AC = mali_pkg::AXIS_COUNT;
   localparam logic [IW-1:0] AXIS_LAST = IW'(AC - 1);

   // saturate a target at the angle limit
   function automatic logic [AW-1:0] clamp_angle(input logic [AW-1:0] tgt);
      logic [AW-1:0] res;
      res = tgt;
      if (32'(tgt) > mali_pkg::ANGLE_LIMIT_Q) begin
         res = AW'(mali_pkg::ANGLE_LIMIT_Q);
      end
      return res;
   endfunction

   mali_pkg::state_type   state_ff, state_in;
   logic [IW-1:0]         axis_ff, axis_in;
   logic                  issued_ff, issued_in;
   logic                  busy_ff, busy_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // per-axis storage
   logic [AW-1:0]         cur_ff   [AC];
   logic [AW-1:0]         src_ff   [AC];
   logic [AW-1:0]         tgt_ff   [AC];
   logic [AW-1:0]         dmag_ff  [AC];
   logic                  dneg_ff  [AC];
   logic [AW-1:0]         qd_ff    [AC];
   logic [SW-1:0]         rd_ff    [AC];
   logic [AW-1:0]         qacc_ff  [AC];
   logic [SW-1:0]         racc_ff  [AC];

   logic [mali_pkg::SPEED_W-1:0] speed_ff;
   logic [AW-1:0]         max_ff;
   logic [SW-1:0]         total_ff;
   logic [SW-1:0]         index_ff;

   logic [AW-1:0]         rsp_pos_ff [mali_pkg::AXES_MAX];
   logic                  rsp_moving_ff;
   logic                  rsp_last_ff;

   logic [AW-1:0]         tgt_field [mali_pkg::AXES_MAX];
   logic [AW-1:0]         pos_view  [mali_pkg::AXES_MAX];

   mali_pkg::div_req_type div_req;
   mali_pkg::div_rsp_type div_rsp;

   logic                  req_accept;
   logic                  emit_load;

   // scan datapath
   logic [AW:0]           scan_diff;
   logic [AW:0]           scan_mag_w;
   logic [AW-1:0]         scan_mag;
   logic                  scan_neg;
   logic [AW-1:0]         steps_pre;
   logic [SW-1:0]         total_new;

   // tick datapath
   logic [SW:0]           rsum;
   logic                  wrap;
   logic [SW:0]           rsub;
   logic [SW-1:0]         rnext;
   logic [AW-1:0]         qnext;
   logic [AW:0]           pos_w;
   logic [AW-1:0]         cur_new;
   logic [SW-1:0]         index_next;

   assign tgt_field[0] = req_ch.target_shoulder_y;
   assign tgt_field[1] = req_ch.target_shoulder_z;
   assign tgt_field[2] = req_ch.target_elbow_y;
   assign tgt_field[3] = req_ch.target_wrist_y;
   assign tgt_field[4] = req_ch.target_grip_x;
   assign tgt_field[5] = req_ch.target_grip_y;
   assign tgt_field[6] = req_ch.target_grip_z;
   assign tgt_field[7] = req_ch.target_grip_open;

   // unused axes read as zero
   for (genvar g = 0; g < mali_pkg::AXES_MAX; g++) begin : g_view
      if (g < AC) begin : g_used
         assign pos_view[g] = cur_ff[g];
      end else begin : g_unused
         assign pos_view[g] = '0;
      end
   end

   assign req_ch.ready = (state_ff == mali_pkg::ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign emit_load    = (state_ff == mali_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   mali_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // datapath for the axis under the sequencer
   always_comb begin
      scan_diff  = {1'b0, tgt_ff[axis_ff]} - {1'b0, cur_ff[axis_ff]};
      scan_neg   = scan_diff[AW];
      scan_mag_w = scan_neg ? (~scan_diff + 1'b1) : scan_diff;
      scan_mag   = scan_mag_w[AW-1:0];

      steps_pre  = max_ff >> mali_pkg::ANGLE_FRAC_BITS;
      if (steps_pre == '0) begin
         steps_pre = AW'(1);
      end
      total_new = div_rsp.quotient[SW-1:0];
      if (total_new == '0) begin
         total_new = SW'(1);
      end

      // running remainder stays below the step count, so one subtract folds it
      rsum  = {1'b0, racc_ff[axis_ff]} + {1'b0, rd_ff[axis_ff]};
      wrap  = rsum >= {1'b0, total_ff};
      rsub  = rsum - {1'b0, total_ff};
      rnext = wrap ? rsub[SW-1:0] : rsum[SW-1:0];
      qnext = qacc_ff[axis_ff] + qd_ff[axis_ff] + AW'(wrap);
      pos_w = dneg_ff[axis_ff] ? ({1'b0, src_ff[axis_ff]} - {1'b0, qnext})
                               : ({1'b0, src_ff[axis_ff]} + {1'b0, qnext});
      cur_new = (dneg_ff[axis_ff] && pos_w[AW]) ? '0 : pos_w[AW-1:0];

      index_next = index_ff + 1'b1;
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      axis_in          = axis_ff;
      issued_in        = issued_ff;
      busy_in          = busy_ff;
      last_in          = last_ff;
      div_req.start    = 1'b0;
      div_req.dividend = dmag_ff[axis_ff];
      div_req.divisor  = total_ff;
      if (state_ff == mali_pkg::ST_STEP_DIV) begin
         div_req.dividend = steps_pre;
         div_req.divisor  = {1'b0, speed_ff};
      end

      unique case (state_ff)
         mali_pkg::ST_IDLE: begin
            if (req_accept) begin
               axis_in   = '0;
               issued_in = 1'b0;
               if (req_ch.req_type == mali_pkg::REQ_START) begin
                  state_in = mali_pkg::ST_SCAN;
                  busy_in  = 1'b1;
                  last_in  = 1'b0;
               end else if (busy_ff) begin
                  state_in = mali_pkg::ST_TICK;
                  last_in  = index_next >= total_ff;
                  busy_in  = !(index_next >= total_ff);
               end else begin
                  state_in = mali_pkg::ST_EMIT;
                  last_in  = 1'b0;
               end
            end
         end
         mali_pkg::ST_SCAN: begin
            if (axis_ff == AXIS_LAST) begin
               state_in = mali_pkg::ST_STEP_DIV;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         mali_pkg::ST_STEP_DIV: begin
            if (!issued_ff) begin
               div_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (div_rsp.done) begin
               state_in  = mali_pkg::ST_AXIS_DIV;
               axis_in   = '0;
               issued_in = 1'b0;
            end
         end
         mali_pkg::ST_AXIS_DIV: begin
            if (!issued_ff) begin
               div_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (div_rsp.done) begin
               issued_in = 1'b0;
               if (axis_ff == AXIS_LAST) begin
                  state_in = mali_pkg::ST_EMIT;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end
         end
         mali_pkg::ST_TICK: begin
            if (axis_ff == AXIS_LAST) begin
               state_in = mali_pkg::ST_EMIT;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         mali_pkg::ST_EMIT: begin
            if (emit_load) begin
               state_in = mali_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mali_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mali_pkg::ST_IDLE;
         axis_ff      <= '0;
         issued_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         issued_ff    <= issued_in;
         busy_ff      <= busy_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // current pose: reset to zero, written by the tick walk
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AC; i++) begin
            cur_ff[i] <= '0;
         end
      end else if (state_ff == mali_pkg::ST_TICK) begin
         cur_ff[axis_ff] <= cur_new;
      end
   end

   // move data
   always_ff @(posedge clock) begin
      if (req_accept && (req_ch.req_type == mali_pkg::REQ_START)) begin
         for (int i = 0; i < AC; i++) begin
            tgt_ff[i] <= clamp_angle(tgt_field[i]);
         end
         speed_ff <= (req_ch.move_speed == '0) ? mali_pkg::SPEED_W'(1) : req_ch.move_speed;
         max_ff   <= '0;
      end
      if (req_accept && (req_ch.req_type != mali_pkg::REQ_START) && busy_ff) begin
         index_ff <= index_next;
      end
      if (state_ff == mali_pkg::ST_SCAN) begin
         src_ff[axis_ff]  <= cur_ff[axis_ff];
         dmag_ff[axis_ff] <= scan_mag;
         dneg_ff[axis_ff] <= scan_neg;
         if (scan_mag > max_ff) begin
            max_ff <= scan_mag;
         end
      end
      if ((state_ff == mali_pkg::ST_STEP_DIV) && issued_ff && div_rsp.done) begin
         total_ff <= total_new;
         index_ff <= '0;
      end
      if ((state_ff == mali_pkg::ST_AXIS_DIV) && issued_ff && div_rsp.done) begin
         qd_ff[axis_ff]   <= div_rsp.quotient;
         rd_ff[axis_ff]   <= div_rsp.remainder;
         qacc_ff[axis_ff] <= '0;
         racc_ff[axis_ff] <= '0;
      end
      if (state_ff == mali_pkg::ST_TICK) begin
         qacc_ff[axis_ff] <= qnext;
         racc_ff[axis_ff] <= rnext;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_pos_ff    <= pos_view;
         rsp_moving_ff <= busy_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.pos_shoulder_y = rsp_pos_ff[0];
   assign rsp_ch.pos_shoulder_z = rsp_pos_ff[1];
   assign rsp_ch.pos_elbow_y    = rsp_pos_ff[2];
   assign rsp_ch.pos_wrist_y    = rsp_pos_ff[3];
   assign rsp_ch.pos_grip_x     = rsp_pos_ff[4];
   assign rsp_ch.pos_grip_y     = rsp_pos_ff[5];
   assign rsp_ch.pos_grip_z     = rsp_pos_ff[6];
   assign rsp_ch.pos_grip_open  = rsp_pos_ff[7];
   assign rsp_ch.moving         = rsp_moving_ff;
   assign rsp_ch.last_step      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_index_in_move: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (state_ff == mali_pkg::ST_IDLE)) |-> (index_ff < total_ff))
      else $error("step index reached step count while still moving");
   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mali_pkg::ST_TICK) |-> (racc_ff[axis_ff] < total_ff))
      else $error("axis remainder accumulator out of range");
   a_last_ends_move: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> !rsp_moving_ff)
      else $error("final step reported with move still running");
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> ((state_ff == mali_pkg::ST_STEP_DIV) ||
                        (state_ff == mali_pkg::ST_AXIS_DIV)))
      else $error("divider finished outside a divide phase");
`endif

endmodule

>>> dv/mali_scoreboard.sv
// Scoreboard of the interpolator: mirrors the move generator and checks every result item.
module mali_scoreboard
   import mali_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   mali_req_if   req_mon,
   mali_rsp_if   rsp_mon,
   output int    fail_count,
   output int    pending,
   output logic  move_active,
   output int    results_seen,
   output int    finals_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AXES_LIVE = (AXIS_COUNT > AXES_MAX) ? AXES_MAX : AXIS_COUNT;

   typedef logic [AXES_MAX-1:0][ANGLE_W-1:0] pose_vec_t;

   typedef struct packed {
      pose_vec_t pos;
      logic      moving;
      logic      last_step;
   } pose_item_t;

   // mirrored move state
   pose_vec_t          cur_pose;
   pose_vec_t          move_origin;
   int                 travel [AXES_MAX];
   logic [STEP_W-1:0]  step_count;
   logic [STEP_W-1:0]  step_pos;
   logic               busy;
   pose_item_t         due_q [$];

   function automatic string axis_name(input int idx);
      case (idx)
         0:       return "pos_shoulder_y";
         1:       return "pos_shoulder_z";
         2:       return "pos_elbow_y";
         3:       return "pos_wrist_y";
         4:       return "pos_grip_x";
         5:       return "pos_grip_y";
         6:       return "pos_grip_z";
         default: return "pos_grip_open";
      endcase
   endfunction

   function automatic void flag(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
   endfunction

   // latch source pose, deltas and step count for a new move
   function automatic void launch_move(input pose_vec_t goals, input logic [SPEED_W-1:0] speed);
      int unsigned widest;
      int unsigned span;
      int unsigned steps;
      int unsigned pace;
      int          goal;
      widest = 0;
      for (int i = 0; i < AXES_LIVE; i++) begin
         goal = int'(goals[i]);
         if (goal > int'(ANGLE_LIMIT_Q))
            goal = int'(ANGLE_LIMIT_Q);
         move_origin[i] = cur_pose[i];
         travel[i]      = goal - int'(cur_pose[i]);
         span           = (travel[i] < 0) ? -travel[i] : travel[i];
         if (span > widest)
            widest = span;
      end
      steps = widest >> ANGLE_FRAC_BITS;
      if (steps == 0)
         steps = 1;
      pace  = (speed == 0) ? 1 : speed;
      steps = steps / pace;
      if (steps == 0)
         steps = 1;
      step_count = steps[STEP_W-1:0];
      if (step_count == 0)
         step_count = 1;
      step_pos = '0;
      busy     = 1'b1;
   endfunction

   // one step along the line; quotient truncates toward zero
   function automatic logic advance_move();
      longint part;
      longint spot;
      step_pos = step_pos + 1'b1;
      for (int i = 0; i < AXES_LIVE; i++) begin
         part = (longint'(travel[i]) * longint'(step_pos)) / longint'(step_count);
         spot = longint'(move_origin[i]) + part;
         if (spot < 0)
            spot = 0;
         cur_pose[i] = spot[ANGLE_W-1:0];
      end
      if (step_pos >= step_count) begin
         busy = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      pose_item_t want;
      pose_item_t got;
      logic       fin;
      if (reset) begin
         cur_pose    = '0;
         move_origin = '0;
         foreach (travel[i])
            travel[i] = 0;
         step_count   = '0;
         step_pos     = '0;
         busy         = 1'b0;
         due_q.delete();
         fail_count   = 0;
         results_seen = 0;
         finals_seen  = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            fin = 1'b0;
            if (req_mon.req_type == REQ_START)
               launch_move({req_mon.target_grip_open, req_mon.target_grip_z,
                            req_mon.target_grip_y, req_mon.target_grip_x,
                            req_mon.target_wrist_y, req_mon.target_elbow_y,
                            req_mon.target_shoulder_z, req_mon.target_shoulder_y},
                           req_mon.move_speed);
            else if (busy)
               fin = advance_move();
            want.pos       = cur_pose;
            want.moving    = busy;
            want.last_step = fin;
            due_q.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.pos = {rsp_mon.pos_grip_open, rsp_mon.pos_grip_z, rsp_mon.pos_grip_y,
                       rsp_mon.pos_grip_x, rsp_mon.pos_wrist_y, rsp_mon.pos_elbow_y,
                       rsp_mon.pos_shoulder_z, rsp_mon.pos_shoulder_y};
            got.moving    = rsp_mon.moving;
            got.last_step = rsp_mon.last_step;
            results_seen++;
            if (due_q.size() == 0) begin
               $error("result item with no expectation waiting");
               fail_count++;
            end else begin
               want = due_q.pop_front();
               for (int i = 0; i < AXES_MAX; i++)
                  if (want.pos[i] !== got.pos[i])
                     flag(axis_name(i), want.pos[i], got.pos[i]);
               if (want.moving !== got.moving)
                  flag("moving", want.moving, got.moving);
               if (want.last_step !== got.last_step)
                  flag("last_step", want.last_step, got.last_step);
               if (want.last_step)
                  finals_seen++;
            end
         end
      end
      pending     <= due_q.size();
      move_active <= busy;
   end

endmodule

>>> dv/multi_axis_linear_interpolator_unit_tb.sv
// Testbench top of the interpolator: clock, reset, request and result traffic, verdict.
module multi_axis_linear_interpolator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mali_pkg::*;

   // the package only names the start code; a tick is the other value
   localparam logic REQ_TICK   = ~REQ_START;
   localparam int   ITEM_GOAL  = 1000;
   localparam int   ANGLE_TOP  = int'(ANGLE_LIMIT_Q);
   localparam int   ANGLE_ALL  = (1 << ANGLE_W) - 1;
   localparam int   DRAIN_WAIT = 250;

   typedef logic [AXES_MAX-1:0][ANGLE_W-1:0] goal_vec_t;

   // receiver behaviour modes, chosen at random
   typedef enum int {
      FLOW_FREE,
      FLOW_RANDOM,
      FLOW_PERIODIC,
      FLOW_SPARSE
   } flow_mode_t;

   logic clock = 1'b0;
   logic reset;

   mali_req_if req_ch ();
   mali_rsp_if rsp_ch ();

   int        fail_count;
   int        pending;
   logic      move_active;
   int        results_seen;
   int        finals_seen;
   int        items_sent;
   int        starts_sent;
   int        ticks_sent;
   int        burst_left;
   goal_vec_t last_goals;

   multi_axis_linear_interpolator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // The scoreboard predicts every result item and hands back the failure count,
   // the number of results still owed and whether its model has a move running.
   mali_scoreboard scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .fail_count   (fail_count),
      .pending      (pending),
      .move_active  (move_active),
      .results_seen (results_seen),
      .finals_seen  (finals_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Targets for a move. Near moves sit around the last commanded pose, so the
   // step count stays small; far ones span the range, some beyond the limit.
   function automatic goal_vec_t pick_goals(input bit near, input bit beyond, input int spread);
      goal_vec_t g;
      int        val;
      for (int i = 0; i < AXES_MAX; i++) begin
         if (near)
            val = int'(last_goals[i]) + int'($urandom_range(0, 2 * spread)) - spread;
         else if (beyond)
            val = int'($urandom_range(0, ANGLE_ALL));
         else
            val = int'($urandom_range(0, ANGLE_TOP));
         if (val < 0)
            val = 0;
         if (val > ANGLE_ALL)
            val = ANGLE_ALL;
         g[i] = val[ANGLE_W-1:0];
      end
      return g;
   endfunction

   // Offers one item and returns at the edge where it is taken. The sender
   // works in bursts: when a burst runs out, valid drops for a random gap,
   // sometimes long enough to cover a whole start computation.
   task automatic push(input logic kind, input goal_vec_t goals, input logic [SPEED_W-1:0] speed);
      req_ch.valid             <= 1'b1;
      req_ch.req_type          <= kind;
      req_ch.target_shoulder_y <= goals[0];
      req_ch.target_shoulder_z <= goals[1];
      req_ch.target_elbow_y    <= goals[2];
      req_ch.target_wrist_y    <= goals[3];
      req_ch.target_grip_x     <= goals[4];
      req_ch.target_grip_y     <= goals[5];
      req_ch.target_grip_z     <= goals[6];
      req_ch.target_grip_open  <= goals[7];
      req_ch.move_speed        <= speed;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      items_sent++;
      if (kind == REQ_START) begin
         starts_sent++;
         // remember where the arm is heading (saturated) for near moves
         for (int i = 0; i < AXES_MAX; i++)
            last_goals[i] = (goals[i] > ANGLE_TOP) ? ANGLE_W'(ANGLE_TOP) : goals[i];
      end else begin
         ticks_sent++;
      end
      burst_left--;
      if (burst_left <= 0) begin
         req_ch.valid <= 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 8))
            @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      end
   endtask

   // Receiver: ready follows a pattern of its own, with free-flowing stretches.
   // Twice it holds ready low while the sender keeps offering items, so the
   // output register fills and the block stops taking requests.
   initial begin
      int         cyc;
      int         mode_left;
      flow_mode_t mode;
      cyc       = 0;
      mode_left = 0;
      mode      = FLOW_FREE;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (mode_left == 0) begin
            mode      = flow_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(100, 400);
         end
         mode_left--;
         if ((cyc >= 6000 && cyc < 6500) || (cyc >= 15000 && cyc < 15500)) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               FLOW_FREE:     rsp_ch.ready <= 1'b1;
               FLOW_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 2) != 0);
               FLOW_PERIODIC: rsp_ch.ready <= ((cyc % 7) >= 3);
               default:       rsp_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // Stimulus: a directed opening, then random moves until the item count is reached.
   initial begin
      goal_vec_t        g;
      logic [SPEED_W-1:0] speed;
      int               roll;
      int               quit_after;
      int               ticks_in_move;
      bit               near;

      reset                    <= 1'b1;
      req_ch.valid             <= 1'b0;
      req_ch.req_type          <= REQ_TICK;
      req_ch.target_shoulder_y <= '0;
      req_ch.target_shoulder_z <= '0;
      req_ch.target_elbow_y    <= '0;
      req_ch.target_wrist_y    <= '0;
      req_ch.target_grip_x     <= '0;
      req_ch.target_grip_y     <= '0;
      req_ch.target_grip_z     <= '0;
      req_ch.target_grip_open  <= '0;
      req_ch.move_speed        <= '0;
      items_sent  = 0;
      starts_sent = 0;
      ticks_sent  = 0;
      burst_left  = 8;
      last_goals  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // idle tick straight out of reset, all ignored fields at ones
      push(REQ_TICK, '1, '1);
      // every target far above the limit: saturates, 270 degrees over speed 255 is one step
      push(REQ_START, '1, '1);
      push(REQ_TICK, '0, '0);
      push(REQ_TICK, '0, '0);
      // all the way back to zero in two steps
      push(REQ_START, '0, 8'd128);
      repeat (3) push(REQ_TICK, '0, '0);
      // speed zero taken as one: three degrees, three steps, uneven per axis
      g = {17'd767, 17'd0, 17'd600, 17'd512, 17'd255, 17'd3, 17'd700, 17'd768};
      push(REQ_START, g, 8'd0);
      repeat (3) push(REQ_TICK, '1, '1);
      // every delta under one degree: the step count is raised to one
      g = {17'd700, 17'd150, 17'd700, 17'd400, 17'd400, 17'd100, 17'd600, 17'd900};
      push(REQ_START, g, 8'd7);
      push(REQ_TICK, '0, '0);
      // far move in six steps, some axes going down; abandoned after two steps
      g = {17'd0, ANGLE_W'(ANGLE_TOP), 17'd0, ANGLE_W'(ANGLE_TOP),
           17'd0, ANGLE_W'(ANGLE_TOP), 17'd0, ANGLE_W'(ANGLE_TOP)};
      push(REQ_START, g, 8'd40);
      repeat (2) push(REQ_TICK, '0, '0);
      // start while busy: new move from the intermediate pose
      push(REQ_START, '1, 8'd200);
      repeat (2) push(REQ_TICK, '0, '0);
      // five degrees at top speed: quotient zero, raised to one step
      push(REQ_START, {AXES_MAX{ANGLE_W'(ANGLE_TOP - 1280)}}, 8'd255);
      push(REQ_TICK, '0, '0);

      // Random moves: a start, then ticks until the scoreboard's model says the
      // move is over. Its flag is read in the accept step, so it lags one item
      // and a move usually ends with one idle tick. A few moves are cut short
      // by a new start, and now and then stray idle ticks come between moves.
      while (items_sent < ITEM_GOAL) begin
         roll = $urandom_range(0, 9);
         near = (roll < 6);
         g    = pick_goals(near, roll == 9, $urandom_range(0, 3000));
         if (near) begin
            speed = SPEED_W'($urandom_range(0, 255));
         end else begin
            roll = $urandom_range(0, 9);
            if (roll < 6)
               speed = SPEED_W'($urandom_range(16, 255));
            else if (roll < 9)
               speed = SPEED_W'($urandom_range(1, 15));
            else
               speed = '0;
         end
         push(REQ_START, g, speed);
         quit_after    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
         ticks_in_move = 0;
         do begin
            push(REQ_TICK, pick_goals(1'b0, 1'b1, 0), SPEED_W'($urandom_range(0, 255)));
            ticks_in_move++;
         end while (move_active && (quit_after == 0 || ticks_in_move < quit_after));
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
               push(REQ_TICK, pick_goals(1'b0, 1'b1, 0), SPEED_W'($urandom_range(0, 255)));
      end
      req_ch.valid <= 1'b0;

      // the owed count is registered, so look from the next edge on
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("summary: %0d items sent, %0d move starts and %0d ticks",
               items_sent, starts_sent, ticks_sent);
      $display("summary: %0d result items checked, %0d moves reached their final step",
               results_seen, finals_seen);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
